FILE: sv/cmmn_pkg.sv
package cmmn_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	// quotient never exceeds one in q16.16 since the numerator is at most the range
	localparam int QUOT_W = FRAC_W + 1;
	localparam int STEP_W = $clog2(QUOT_W);

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [DATA_W-1:0] mag_t;
	typedef logic [QUOT_W-1:0] quot_t;
	typedef logic [STEP_W-1:0] step_t;

endpackage

FILE: sv/cmmn_ram.sv
module cmmn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/column_min_max_normalizer_core.sv
// channel   ports                                        transfer
// input     start, busy, sample, last_in_column          edge with start high, busy low
// result    strobe, scaled, last_of_run, overflowed      edge ending each strobe cycle
//
// samples without the last mark take one cycle each and never raise busy
// on a last-marked sample the column is replayed from the store: each element passes
// through a ram read, a load state and the steps of the restoring divider,
// or skips the divider when the column is constant
// the divider loop and the single ram read port keep one element in work at a time
// no clearing pass after reset; results cannot be stalled
module column_min_max_normalizer_core #(
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmmn_pkg::sample_t sample,
	input  logic              last_in_column,
	output logic              strobe,
	output cmmn_pkg::sample_t scaled,
	output logic              last_of_run,
	output logic              overflowed
);

	import cmmn_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ROWS);
	localparam step_t STEP_LAST = STEP_W'(QUOT_W - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic ovf_q;
	sample_t min_q;
	sample_t max_q;
	mag_t den_q;
	logic const_q;
	logic [DATA_W:0] rem_q;
	quot_t quot_q;
	step_t step_q;
	logic strobe_q;
	sample_t scaled_q;
	logic last_q;
	logic ovf_out_q;

	logic accept;
	logic store_en;
	sample_t rd_data;
	logic [DATA_W:0] diff_x;
	logic [DATA_W:0] diff_r;
	logic ge;
	logic [DATA_W:0] rem_sub;
	quot_t quot_next;
	logic is_last;

	assign accept = start && (state_q == ST_IDLE);
	assign store_en = accept && (count_q != FULL_CNT);
	assign busy = (state_q != ST_IDLE);

	cmmn_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ROWS)
	) u_store (
		.clk  (clk),
		.we   (store_en),
		.waddr(count_q[AW-1:0]),
		.wdata(sample),
		.re   (state_q == ST_READ),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign diff_x = {rd_data[DATA_W-1], rd_data} - {min_q[DATA_W-1], min_q};
	assign diff_r = {max_q[DATA_W-1], max_q} - {min_q[DATA_W-1], min_q};
	assign ge = (rem_q >= {1'b0, den_q});
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;
	assign quot_next = {quot_q[QUOT_W-2:0], ge};
	assign is_last = (idx_q + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			ovf_q <= 1'b0;
			min_q <= '0;
			max_q <= '0;
			den_q <= '0;
			const_q <= 1'b0;
			rem_q <= '0;
			quot_q <= '0;
			step_q <= '0;
			strobe_q <= 1'b0;
			scaled_q <= '0;
			last_q <= 1'b0;
			ovf_out_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store_en) begin
							count_q <= count_q + CW'(1);
							if (count_q == '0) begin
								min_q <= sample;
								max_q <= sample;
							end else begin
								if (sample < min_q) begin
									min_q <= sample;
								end
								if (sample > max_q) begin
									max_q <= sample;
								end
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_in_column) begin
							idx_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					den_q <= diff_r[DATA_W-1:0];
					const_q <= (max_q == min_q);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rem_q <= {1'b0, diff_x[DATA_W-1:0]};
					quot_q <= '0;
					step_q <= '0;
					if (const_q) begin
						strobe_q <= 1'b1;
						scaled_q <= rd_data;
						last_q <= is_last;
						ovf_out_q <= ovf_q;
						if (is_last) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							ovf_q <= 1'b0;
							min_q <= '0;
							max_q <= '0;
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= ST_READ;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quot_q <= quot_next;
					rem_q <= {rem_sub[DATA_W-1:0], 1'b0};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						strobe_q <= 1'b1;
						scaled_q <= sample_t'({{(DATA_W - QUOT_W){1'b0}}, quot_next});
						last_q <= is_last;
						ovf_out_q <= ovf_q;
						if (is_last) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							ovf_q <= 1'b0;
							min_q <= '0;
							max_q <= '0;
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign scaled = scaled_q;
	assign last_of_run = last_q;
	assign overflowed = ovf_out_q;

endmodule

FILE: sv/cmmn_checker.sv
module cmmn_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in_column,
	input logic strobe,
	input logic last_of_run
);

	import cmmn_pkg::*;

	// emission starts only after a last-marked transfer
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last_in_column))
		else $error("busy rose without a last-marked transfer");

	// emission ends only with the final result
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last_of_run))
		else $error("busy fell without the final result");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_of_run) |-> busy)
		else $error("non-final result outside a run");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_of_run) |-> !busy)
		else $error("still busy after the final result");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("results on adjacent cycles");

endmodule

bind column_min_max_normalizer_core cmmn_checker u_cmmn_checker (.*);
